// ===== rtl/fbpw_pkg.sv =====
package fbpw_pkg;

  localparam int CFG_W = 9;
  localparam int CH_W = 8;
  localparam int NUM_CH = 3;
  localparam int ALPHA_LSB = 24;
  localparam int MIX_W = 16;

  localparam logic [1:0] ACT_PLAIN = 2'd0;
  localparam logic [1:0] ACT_BLEND = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_WRITTEN = 2'd0;
  localparam logic [1:0] STATUS_CLIPPED = 2'd1;
  localparam logic [1:0] STATUS_CLEARED = 2'd2;

  localparam logic [7:0] CH_MAX = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DONE,
    ST_CLEAR
  } state_t;

  function automatic logic [CH_W-1:0] div255(input logic [MIX_W-1:0] x);
    logic [MIX_W:0] t;
    t = {1'b0, x} + {9'd0, x[MIX_W-1:CH_W]} + 17'd1;
    return t[MIX_W-1:CH_W];
  endfunction

endpackage

// ===== rtl/framebuffer_pixel_writer_alpha.sv =====
// A plain write or a clipped item goes from accept straight to its result, a blend passes
// through address, memory read, multiply and write back; one item is in work at a time.
// A clear sweeps the frame through the single write port, one pixel per cycle, before its
// result word; an empty frame goes straight to its result word.
// Reset is synchronous and active low; it restores width and height to 256 and leaves
// the pixel memory undefined until written or cleared.
module framebuffer_pixel_writer_alpha import fbpw_pkg::*; #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // action[1:0], pos_x[17:2], pos_y[33:18], color[65:34], zero[71:66]
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], stored_value[33:2], zero[39:34]
  output logic [39:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CFG_W-1:0] width_r, height_r;
  logic [CFG_W-1:0] act_w, act_h;
  logic             cfg_wr;

  state_t state_r, state_nxt;

  logic [1:0]      action;
  logic [15:0]     pos_x, pos_y;
  logic [31:0]     color;
  logic            in_acc;
  logic            in_frame;
  logic [18:0]     addr_full;
  logic [17:0]     count;

  logic [AW-1:0]   addr_r;
  logic [31:0]     color_r;
  logic [31:0]     value_r;
  logic [1:0]      status_r;
  logic            wr_r;
  logic            blend_r;
  logic [17:0]     last_r;
  logic [AW-1:0]   cnt_r;

  logic            out_valid_r;
  logic [33:0]     out_data_r;
  logic            out_free;
  logic            done_go;
  logic [31:0]     final_value;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr;
  logic [31:0]     ram_wdata, ram_rdata;
  logic [23:0]     mix;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) begin
        height_r <= cfg_pwdata[CFG_W-1:0];
      end else begin
        width_r <= cfg_pwdata[CFG_W-1:0];
      end
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? {23'd0, height_r} : {23'd0, width_r};

  assign act_w = (32'(width_r) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : width_r;
  assign act_h = (32'(height_r) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : height_r;

  assign action = in_tdata[1:0];
  assign pos_x  = in_tdata[17:2];
  assign pos_y  = in_tdata[33:18];
  assign color  = in_tdata[65:34];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc = in_tvalid && in_tready;

  assign in_frame = !pos_x[15] && !pos_y[15]
                 && (pos_x[14:0] < {6'd0, act_w}) && (pos_y[14:0] < {6'd0, act_h});
  assign addr_full = 19'(pos_y[CFG_W-1:0] * act_w) + 19'(pos_x[CFG_W-1:0]);
  assign count = 18'(act_w * act_h);

  assign out_free = !out_valid_r || out_tready;
  assign done_go = (state_r == ST_DONE) && out_free;
  assign final_value = blend_r ? {8'd0, mix} : value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = final_value;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (action == ACT_CLEAR) begin
            state_nxt = (count == 18'd0) ? ST_DONE : ST_CLEAR;
          end else if (action == ACT_BLEND && in_frame) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_READ: begin
        ram_re    = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ram_we    = wr_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = 32'd0;
        if (18'(cnt_r) == last_r) begin
          state_nxt = ST_DONE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r  <= AW'(addr_full);
      color_r <= color;
      last_r  <= count - 18'd1;
      blend_r <= 1'b0;
      wr_r    <= 1'b0;
      value_r <= 32'd0;
      status_r <= STATUS_CLIPPED;
      if (action == ACT_CLEAR) begin
        status_r <= STATUS_CLEARED;
      end else if (in_frame && action == ACT_PLAIN) begin
        status_r <= STATUS_WRITTEN;
        wr_r     <= 1'b1;
        value_r  <= color;
      end else if (in_frame && action == ACT_BLEND) begin
        status_r <= STATUS_WRITTEN;
        wr_r     <= 1'b1;
        blend_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= '0;
    end else if (state_r == ST_CLEAR) begin
      cnt_r <= cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_data_r <= {final_value, status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

  fbpw_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(addr_r),
    .rdata(ram_rdata)
  );

  fbpw_blend u_blend (
    .clk    (clk),
    .en     (state_r == ST_MUL),
    .old_pix(ram_rdata),
    .new_pix(color_r),
    .mix    (mix)
  );

endmodule

// ===== rtl/fbpw_ram.sv =====
module fbpw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fbpw_blend.sv =====
module fbpw_blend import fbpw_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] old_pix,
  input  logic [31:0] new_pix,
  output logic [23:0] mix
);

  logic [MIX_W-1:0] sum_r   [NUM_CH];
  logic [MIX_W-1:0] sum_nxt [NUM_CH];
  logic [CH_W-1:0]  alpha;
  logic [CH_W-1:0]  inv_alpha;

  assign alpha = new_pix[ALPHA_LSB +: CH_W];
  assign inv_alpha = CH_MAX - alpha;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      sum_nxt[i] = MIX_W'(old_pix[i*CH_W +: CH_W] * inv_alpha)
                 + MIX_W'(new_pix[i*CH_W +: CH_W] * alpha);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_CH; i++) begin
        sum_r[i] <= sum_nxt[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      mix[i*CH_W +: CH_W] = div255(sum_r[i]);
    end
  end

endmodule

// ===== tb/tb_framebuffer_pixel_writer_alpha.sv =====
module tb_framebuffer_pixel_writer_alpha;
  import fbpw_pkg::*;

  localparam int FB_W = 256;
  localparam int FB_H = 256;
  localparam int REG_WIDTH = 0;
  localparam int REG_HEIGHT = 1;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam int RANDOM_WORDS = 1050;

  class fb_scoreboard;
    bit [8:0]  width_reg;
    bit [8:0]  height_reg;
    bit [31:0] shadow [FB_W*FB_H];
    bit        written [FB_W*FB_H];
    bit [1:0]  pending_status [$];
    bit [31:0] pending_pixel [$];
    int        mismatches;

    function new();
      width_reg = 9'd256;
      height_reg = 9'd256;
      mismatches = 0;
    endfunction

    function int act_w();
      return (width_reg > FB_W) ? FB_W : int'(width_reg);
    endfunction

    function int act_h();
      return (height_reg > FB_H) ? FB_H : int'(height_reg);
    endfunction

    function int frame_addr(bit [15:0] px, bit [15:0] py);
      int x;
      int y;
      x = $signed(px);
      y = $signed(py);
      if (x < 0 || y < 0 || x >= act_w() || y >= act_h()) return -1;
      return y * act_w() + x;
    endfunction

    function bit blend_safe(bit [15:0] px, bit [15:0] py);
      int addr;
      addr = frame_addr(px, py);
      return (addr < 0) ? 1'b1 : written[addr];
    endfunction

    function bit [31:0] blend_pixel(bit [31:0] old, bit [31:0] col);
      int a;
      int o;
      int n;
      bit [31:0] r;
      a = col[31:24];
      r = '0;
      for (int c = 0; c < 3; c++) begin
        o = (old >> (8 * c)) & 255;
        n = (col >> (8 * c)) & 255;
        r = r | (((o * (255 - a) + n * a) / 255) << (8 * c));
      end
      return r;
    endfunction

    function void note_word(bit [1:0] act, bit [15:0] px, bit [15:0] py, bit [31:0] col);
      int addr;
      bit [1:0] st;
      bit [31:0] val;
      st = STATUS_CLIPPED;
      val = '0;
      if (act == ACT_CLEAR) begin
        for (int i = 0; i < act_w() * act_h(); i++) begin
          shadow[i] = '0;
          written[i] = 1'b1;
        end
        st = STATUS_CLEARED;
      end else if (act == ACT_PLAIN || act == ACT_BLEND) begin
        addr = frame_addr(px, py);
        if (addr >= 0) begin
          val = (act == ACT_PLAIN) ? col : blend_pixel(shadow[addr], col);
          shadow[addr] = val;
          written[addr] = 1'b1;
          st = STATUS_WRITTEN;
        end
      end
      pending_status.push_back(st);
      pending_pixel.push_back(val);
    endfunction

    function void check_word(logic [1:0] st, logic [31:0] val);
      bit [1:0] es;
      bit [31:0] ev;
      if (pending_status.size() == 0) begin
        if (mismatches < 10) $display("unexpected word: status %0d value %h", st, val);
        mismatches++;
        return;
      end
      es = pending_status.pop_front();
      ev = pending_pixel.pop_front();
      if (st !== es || val !== ev) begin
        if (mismatches < 10)
          $display("mismatch: status %0d (expected %0d) value %h (expected %h)",
                   st, es, val, ev);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_status.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  fb_scoreboard sb = new();

  always #2 clk = ~clk;

  framebuffer_pixel_writer_alpha #(
    .MAX_WIDTH(FB_W),
    .MAX_HEIGHT(FB_H)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 250;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_word(out_tdata[1:0], out_tdata[33:2]);
    end
  end

  task automatic send_word(bit [1:0] act, bit [15:0] px, bit [15:0] py, bit [31:0] col);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, col, py, px, act};
    do @(posedge clk); while (!in_tready);
    sb.note_word(act, px, py, col);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(int idx, bit [8:0] val);
    bit [31:0] d;
    d = $urandom;
    d[8:0] = val;
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 3'(idx * 4);
    cfg_pwdata <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_WIDTH) sb.width_reg = val;
    else sb.height_reg = val;
    @(posedge clk);
  endtask

  task automatic set_frame(bit [8:0] w, bit [8:0] h);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic random_word(output bit counted);
    int w;
    int h;
    int r;
    int x;
    int y;
    bit [1:0] act;
    bit [31:0] col;
    w = sb.act_w();
    h = sb.act_h();
    r = $urandom_range(0, 99);
    if (r < 45) act = ACT_PLAIN;
    else if (r < 90) act = ACT_BLEND;
    else if (r < 95) act = ACT_CLEAR;
    else act = ACT_UNKNOWN;
    if (act == ACT_CLEAR && w * h > 1024) act = ACT_PLAIN;
    r = $urandom_range(0, 99);
    if (r < 70 && w > 0 && h > 0) begin
      x = $urandom_range(0, w - 1);
      y = $urandom_range(0, h - 1);
    end else if (r < 85) begin
      x = int'($urandom_range(0, w + 3)) - 2;
      y = int'($urandom_range(0, h + 3)) - 2;
    end else begin
      x = $urandom;
      y = $urandom;
    end
    col = $urandom;
    r = $urandom_range(0, 9);
    if (r == 0) col[31:24] = 8'h00;
    else if (r == 1) col[31:24] = 8'hFF;
    if (act == ACT_BLEND && !sb.blend_safe(16'(x), 16'(y))) act = ACT_PLAIN;
    send_word(act, 16'(x), 16'(y), col);
    counted = (act != ACT_UNKNOWN);
  endtask

  initial begin
    bit [8:0] pw [8];
    bit [8:0] ph [8];
    int count;
    int phase;
    bit counted;
    pw = '{9'd1, 9'd0, 9'd7, 9'd256, 9'd511, 9'd257, 9'd1, 9'd255};
    ph = '{9'd1, 9'd5, 9'd0, 9'd256, 9'd300, 9'd1, 9'd256, 9'd255};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_word(ACT_PLAIN, 16'd0, 16'd0, 32'hFF123456);
    send_word(ACT_BLEND, 16'd0, 16'd0, 32'h80ABCDEF);
    send_word(ACT_BLEND, 16'd0, 16'd0, 32'h00FFFFFF);
    send_word(ACT_BLEND, 16'd0, 16'd0, 32'hFF00FF00);
    send_word(ACT_PLAIN, 16'd255, 16'd255, 32'hFFFFFFFF);
    send_word(ACT_PLAIN, 16'd255, 16'd0, 32'h00000000);
    send_word(ACT_PLAIN, 16'd0, 16'd255, 32'hA5A5A5A5);
    send_word(ACT_BLEND, 16'd255, 16'd255, 32'h40102030);
    send_word(ACT_PLAIN, 16'd256, 16'd0, 32'h5A5A5A5A);
    send_word(ACT_PLAIN, 16'd0, 16'd256, 32'h12345678);
    send_word(ACT_BLEND, 16'hFFFF, 16'd0, 32'hFFFFFFFF);
    send_word(ACT_BLEND, 16'd0, 16'hFFFF, 32'hFFFFFFFF);
    send_word(ACT_PLAIN, 16'h8000, 16'h8000, 32'hFFFFFFFF);
    send_word(ACT_PLAIN, 16'h7FFF, 16'h7FFF, 32'hFFFFFFFF);
    send_word(ACT_PLAIN, 16'h7FFF, 16'h8000, 32'h87654321);
    send_word(ACT_UNKNOWN, 16'd10, 16'd10, 32'hDEADBEEF);
    send_word(ACT_UNKNOWN, 16'hFFFB, 16'd400, 32'hFFFFFFFF);
    send_word(ACT_CLEAR, 16'd0, 16'd0, 32'h00000000);
    send_word(ACT_BLEND, 16'd100, 16'd200, 32'hFF7F7F7F);
    send_word(ACT_BLEND, 16'd100, 16'd200, 32'h7F80FF01);
    send_word(ACT_BLEND, 16'd255, 16'd255, 32'hC0FFFFFF);
    send_word(ACT_PLAIN, 16'd17, 16'd3, 32'h00FF00FF);

    count = 0;
    phase = 0;
    while (count < RANDOM_WORDS) begin
      if (phase < 8) set_frame(pw[phase], ph[phase]);
      else set_frame(9'($urandom_range(1, 32)), 9'($urandom_range(1, 32)));
      no_idle = (phase % 5 == 3);
      if (phase == 2 || phase == 11) hold_req = 1'b1;
      if (phase == 4) send_word(ACT_CLEAR, 16'($urandom), 16'($urandom), $urandom);
      for (int i = 0; i < 44 && count < RANDOM_WORDS; i++) begin
        random_word(counted);
        count += counted;
      end
      phase++;
    end
    no_idle = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
